@@ rtl/lesf_pkg.sv @@
// Shared types and constants for the largest empty square finder.
// No dependencies; the interfaces, the top level and the checker import this package.
package lesf_pkg;

   // default grid bounds for the top-level parameters
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   // configuration port
   localparam int CSR_DATA_W = 11;
   localparam int CSR_ADDR_W = 1;

   localparam logic [CSR_ADDR_W-1:0] REG_GRID_WIDTH  = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_GRID_HEIGHT = 1'd1;

   // result field widths
   localparam int SIZE_OUT_W = 11;
   localparam int POS_OUT_W  = 10;

   // one result as held in the output queue
   typedef struct packed {
      logic [SIZE_OUT_W-1:0] square_size;
      logic [POS_OUT_W-1:0]  top_row;
      logic [POS_OUT_W-1:0]  left_col;
   } res_type;

endpackage

@@ rtl/lesf_if.sv @@
// Request and response channel interfaces of the largest empty square finder.
// Depends on lesf_pkg for the result field widths.
interface lesf_req_if;
   logic valid;
   logic ready;
   logic is_obstacle;

   modport source (output valid, output is_obstacle, input ready);
   modport sink   (input valid, input is_obstacle, output ready);
endinterface

interface lesf_rsp_if;
   import lesf_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [SIZE_OUT_W-1:0] square_size;
   logic [POS_OUT_W-1:0]  top_row;
   logic [POS_OUT_W-1:0]  left_col;

   modport source (output valid, output square_size, output top_row, output left_col,
                   input ready);
   modport sink   (input valid, input square_size, input top_row, input left_col,
                   output ready);
endinterface

@@ rtl/lesf_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lesf_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/largest_empty_square_finder.sv @@
// Top level of the largest empty square finder: row buffer, recurrence and result queue.
// Depends on lesf_pkg, lesf_if (channel interfaces) and lesf_ram (row buffer).
//
//   port       dir   handshake         content
//   req_chan   in    valid/ready       is_obstacle, one grid cell in row-major order
//   rsp_chan   out   valid/ready       square_size, top_row, left_col after the last cell
//   csr_*      in    csr_wr_en only    grid_width (index 0), grid_height (index 1)
//
// One cell per cycle while req_chan is ready. A cell reads the row buffer at acceptance
// and is resolved in the next cycle, where the buffer entry is written back; the
// single-column grid case is served by forwarding. A result passes the resolve stage
// and the two-entry result queue before it leaves. The queue holds requests while it
// is full, or while it holds one result and another is being stored, so back-to-back
// single-cell grids see stalls. Reset is synchronous; the row buffer needs no clearing
// since row 0 never reads it.
module largest_empty_square_finder #(
   parameter int MAX_WIDTH  = lesf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = lesf_pkg::DEF_MAX_HEIGHT
) (
   input  logic                            clock,
   input  logic                            reset,
   lesf_req_if.sink                        req_chan,
   lesf_rsp_if.source                      rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [lesf_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [lesf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lesf_pkg::*;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int MIN_DIM = (MAX_WIDTH < MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int SZ_W    = $clog2(MIN_DIM + 1);
   localparam int PW0     = (ROW_W > COL_W) ? ROW_W : COL_W;
   localparam int PW      = ((PW0 > SZ_W) ? PW0 : SZ_W) + 1;

   // grid bounds, kept as last column and last row
   logic [COL_W-1:0] last_col_ff, last_col_in;
   logic [ROW_W-1:0] last_row_ff, last_row_in;
   // position of the next cell
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   // resolve stage
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_obst_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic             s1_last_ff;
   logic             s1_fwd_ff;
   logic [SZ_W-1:0]  s1_fwd_data_ff;
   // neighbor sizes
   logic [SZ_W-1:0]  left_ff, left_in;
   logic [SZ_W-1:0]  diag_ff, diag_in;
   // best square of the current grid
   logic [SZ_W-1:0]  best_size_ff, best_size_in;
   logic [ROW_W-1:0] best_row_ff, best_row_in;
   logic [COL_W-1:0] best_col_ff, best_col_in;
   // result queue
   logic [1:0]       q_cnt_ff, q_cnt_in;
   res_type          q0_ff, q0_in, q1_ff, q1_in;

   logic             accept;
   logic             cfg_restart;
   logic             cell_last;
   logic [SZ_W-1:0]  ram_rd_data;
   logic [SZ_W-1:0]  up_size, left_size, diag_size, min_lu, min_all, cell_size;
   logic [PW-1:0]    top_w, left_w;
   logic [ROW_W-1:0] cand_row;
   logic [COL_W-1:0] cand_col;
   logic             better;
   logic [SZ_W-1:0]  nb_size;
   logic [ROW_W-1:0] nb_row;
   logic [COL_W-1:0] nb_col;
   logic             push, pop;
   logic [1:0]       q_fill;
   res_type          res_new;

   assign accept    = req_chan.valid && req_chan.ready;
   assign cell_last = (col_ff == last_col_ff) && (row_ff == last_row_ff);

   // hold requests while a finished result would find no queue entry
   assign req_chan.ready = (q_cnt_ff == 2'd0) ||
                           ((q_cnt_ff == 2'd1) && !(s1_valid_ff && s1_last_ff));

   // decode configuration writes into clamped bounds
   always_comb begin
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      cfg_restart = 1'b0;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_GRID_WIDTH: begin
               cfg_restart = 1'b1;
               if (csr_wdata == '0) begin
                  last_col_in = '0;
               end else if (32'(csr_wdata) > 32'(MAX_WIDTH)) begin
                  last_col_in = COL_W'(MAX_WIDTH - 1);
               end else begin
                  last_col_in = COL_W'(csr_wdata - 1'b1);
               end
            end
            REG_GRID_HEIGHT: begin
               cfg_restart = 1'b1;
               if (csr_wdata == '0) begin
                  last_row_in = '0;
               end else if (32'(csr_wdata) > 32'(MAX_HEIGHT)) begin
                  last_row_in = ROW_W'(MAX_HEIGHT - 1);
               end else begin
                  last_row_in = ROW_W'(csr_wdata - 1'b1);
               end
            end
            default: begin
               cfg_restart = 1'b0;
            end
         endcase
      end
   end

   // advance the raster position on each request
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg_restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == last_col_ff) begin
            col_in = '0;
            row_in = (row_ff == last_row_ff) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // row buffer: read at acceptance, write back from the resolve stage
   lesf_ram #(
      .WIDTH (SZ_W),
      .DEPTH (MAX_WIDTH)
   ) u_row_buf (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (cell_size),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (ram_rd_data)
   );

   // resolve: neighbors, three-way minimum, new size
   always_comb begin
      if (s1_row_ff == '0) begin
         up_size = '0;
      end else if (s1_fwd_ff) begin
         up_size = s1_fwd_data_ff;
      end else begin
         up_size = ram_rd_data;
      end
      left_size = (s1_col_ff == '0) ? '0 : left_ff;
      diag_size = ((s1_col_ff == '0) || (s1_row_ff == '0)) ? '0 : diag_ff;
      min_lu    = (up_size < left_size) ? up_size : left_size;
      min_all   = (min_lu < diag_size) ? min_lu : diag_size;
      cell_size = s1_obst_ff ? '0 : SZ_W'(min_all + 1'b1);
   end

   // compare against the best square, earliest top-left corner wins ties
   always_comb begin
      top_w    = PW'(s1_row_ff) + 1'b1 - PW'(cell_size);
      left_w   = PW'(s1_col_ff) + 1'b1 - PW'(cell_size);
      cand_row = ROW_W'(top_w);
      cand_col = COL_W'(left_w);
      better   = (cell_size != '0) &&
                 ((cell_size > best_size_ff) ||
                  ((cell_size == best_size_ff) &&
                   ((cand_row < best_row_ff) ||
                    ((cand_row == best_row_ff) && (cand_col < best_col_ff)))));
      nb_size  = better ? cell_size : best_size_ff;
      nb_row   = better ? cand_row : best_row_ff;
      nb_col   = better ? cand_col : best_col_ff;
   end

   assign push = s1_valid_ff && s1_last_ff;

   always_comb begin
      res_new.square_size = SIZE_OUT_W'(nb_size);
      res_new.top_row     = POS_OUT_W'(nb_row);
      res_new.left_col    = POS_OUT_W'(nb_col);
   end

   // update neighbor and best-square state
   always_comb begin
      left_in      = left_ff;
      diag_in      = diag_ff;
      best_size_in = best_size_ff;
      best_row_in  = best_row_ff;
      best_col_in  = best_col_ff;
      if (s1_valid_ff) begin
         left_in = cell_size;
         diag_in = up_size;
      end
      if (cfg_restart || push) begin
         best_size_in = '0;
         best_row_in  = '0;
         best_col_in  = '0;
      end else if (s1_valid_ff) begin
         best_size_in = nb_size;
         best_row_in  = nb_row;
         best_col_in  = nb_col;
      end
   end

   assign s1_valid_in = accept;

   // result queue: pop from the head, push behind what remains
   assign pop    = (q_cnt_ff != 2'd0) && rsp_chan.ready;
   assign q_fill = q_cnt_ff - {1'b0, pop};

   always_comb begin
      q0_in    = q0_ff;
      q1_in    = q1_ff;
      q_cnt_in = q_fill + {1'b0, push};
      if (pop) begin
         q0_in = q1_ff;
      end
      if (push) begin
         priority if (q_fill == 2'd0) begin
            q0_in = res_new;
         end else begin
            q1_in = res_new;
         end
      end
   end

   assign rsp_chan.valid       = (q_cnt_ff != 2'd0);
   assign rsp_chan.square_size = q0_ff.square_size;
   assign rsp_chan.top_row     = q0_ff.top_row;
   assign rsp_chan.left_col    = q0_ff.left_col;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff  <= '0;
         last_row_ff  <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         best_size_ff <= '0;
         best_row_ff  <= '0;
         best_col_ff  <= '0;
         q_cnt_ff     <= 2'd0;
      end else begin
         last_col_ff  <= last_col_in;
         last_row_ff  <= last_row_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         best_size_ff <= best_size_in;
         best_row_ff  <= best_row_in;
         best_col_ff  <= best_col_in;
         q_cnt_ff     <= q_cnt_in;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_obst_ff     <= req_chan.is_obstacle;
         s1_col_ff      <= col_ff;
         s1_row_ff      <= row_ff;
         s1_last_ff     <= cell_last;
         s1_fwd_ff      <= s1_valid_ff && (s1_col_ff == col_ff);
         s1_fwd_data_ff <= cell_size;
      end
      left_ff <= left_in;
      diag_ff <= diag_in;
      q0_ff   <= q0_in;
      q1_ff   <= q1_in;
   end

endmodule

@@ rtl/lesf_checker.sv @@
// Port-level checks for the largest empty square finder, bound to its top level.
// Depends on lesf_pkg for the result field widths.
module lesf_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [lesf_pkg::SIZE_OUT_W-1:0] rsp_square_size,
   input logic [lesf_pkg::POS_OUT_W-1:0]  rsp_top_row,
   input logic [lesf_pkg::POS_OUT_W-1:0]  rsp_left_col
);
   import lesf_pkg::*;

   logic [SIZE_OUT_W + 2*POS_OUT_W - 1:0] rsp_payload;

   assign rsp_payload = {rsp_square_size, rsp_top_row, rsp_left_col};

   // drop pending results on reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // stall requests only while results back up
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with no response waiting");

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("response payload changed while stalled");

   // request handshake; a response that appears on an empty queue comes from the
   // last cell accepted, by way of the resolve stage
   logic req_fire;
   assign req_fire = req_valid && req_ready;

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_fire, 2))
      else $error("response with no request two cycles earlier");

endmodule

bind largest_empty_square_finder lesf_checker u_lesf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_square_size (rsp_chan.square_size),
   .rsp_top_row     (rsp_chan.top_row),
   .rsp_left_col    (rsp_chan.left_col)
);
